FILE: rtl/core/ffha_pkg.sv
package ffha_pkg;

   localparam int ADDR_BITS   = 16;
   localparam int SIZE_W      = ADDR_BITS + 1;
   localparam int HND_W       = 6;
   localparam int MAX_HANDLES = 64;
   localparam int RESULT_CAP  = 64;
   localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_BITS;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_DEREF  = 2'd2,
      OP_DEFRAG = 2'd3
   } req_op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_SPACE   = 3'd1,
      ST_BAD_HANDLE = 3'd2,
      ST_FREED      = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_D_OUT,
      S_A_RD,
      S_A_CHK,
      S_A_HND,
      S_A_SH,
      S_A_SHW,
      S_A_WR1,
      S_A_WR0,
      S_F_RD,
      S_F_CHK,
      S_F_MRG,
      S_RM_RD,
      S_RM_WR,
      S_G_RD,
      S_G_CHK,
      S_G_CPRD,
      S_G_CPWR,
      S_G_END
   } state_type;

   typedef struct packed {
      req_op_type             req_type;
      logic [SIZE_W-1:0]      alloc_size;
      logic [HND_W-1:0]       handle;
   } ffha_req_type;

   typedef struct packed {
      status_type             status;
      logic [HND_W-1:0]       handle_out;
      logic [ADDR_BITS-1:0]   offset;
      logic [ADDR_BITS-1:0]   move_src;
      logic [ADDR_BITS-1:0]   move_dst;
      logic [SIZE_W-1:0]      move_len;
      logic                   last;
   } ffha_rsp_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]   off;
      logic [SIZE_W-1:0]      size;
      logic                   free;
      logic [HND_W-1:0]       owner;
   } seg_entry_type;

   function automatic ffha_rsp_type rsp_of(status_type st, logic [HND_W-1:0] h,
                                           logic [ADDR_BITS-1:0] off);
      ffha_rsp_type r;
      r            = '0;
      r.status     = st;
      r.handle_out = h;
      r.offset     = off;
      r.last       = 1'b1;
      return r;
   endfunction

endpackage

FILE: rtl/core/ffha_seg_table.sv
module ffha_seg_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [AW-1:0]           waddr,
   input  ffha_pkg::seg_entry_type wdata,
   input  logic [AW-1:0]           raddr,
   output ffha_pkg::seg_entry_type rdata
);
   import ffha_pkg::*;

   seg_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: rtl/core/first_fit_handle_allocator.sv
// first-fit handle allocator over a pool of csr_data bytes
//
// requests enter on req_item when start is high and busy is low. alloc
// returns a handle and offset, free releases a handle and merges the
// segment with free neighbours, deref returns the offset of a handle,
// defragment packs used segments to the left and emits one move per
// relocated segment. results appear on rsp_item for one cycle with
// rsp_valid high; rsp_item.last marks the final result of a request.
// the receiver cannot stall, results are never held.
// alloc and free scan the segment table entry by entry and shift the
// entries behind on a split or merge; defragment walks every table entry.
// deref and errors found on entry take no table scan. the segment table
// has a registered read; a request holds busy high until its last result
// is issued.
// csr_data is written when csr_valid and csr_ready are high, only while
// idle, and resets the table to one free segment with no handles.
// reset passes through an init state that writes the first segment, busy high meanwhile.
module first_fit_handle_allocator #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ffha_pkg::ffha_req_type req_item,
   output logic                   rsp_valid,
   output ffha_pkg::ffha_rsp_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [16:0]            csr_data
);
   import ffha_pkg::*;

   localparam int SEG_AW = $clog2(MAX_SEGMENTS);
   localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [SEG_CW:0] SEG_LIM = (SEG_CW + 1)'(MAX_SEGMENTS);

   state_type            state_ff, state_in;
   logic [SIZE_W-1:0]    pool_ff, pool_in;
   logic [SEG_CW-1:0]    cnt_ff, cnt_in;
   logic [SEG_CW-1:0]    idx_ff, idx_in;
   logic [SEG_CW-1:0]    jdx_ff, jdx_in;
   logic [HND_W:0]       top_ff, top_in;
   logic [HND_W:0]       iss_ff, iss_in;
   logic [MAX_HANDLES-1:0] valid_ff, valid_in;
   ffha_req_type         req_ff, req_in;
   seg_entry_type        cur_ff, cur_in;
   seg_entry_type        prev_ff, prev_in;
   logic [SIZE_W-1:0]    dst_ff, dst_in;
   logic [HND_W:0]       nmov_ff, nmov_in;
   ffha_rsp_type         pend_ff, pend_in;
   logic [HND_W-1:0]     hnd_ff, hnd_in;
   logic                 rm2_ff, rm2_in;
   logic                 stop_ff, stop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ffha_rsp_type         rsp_ff, rsp_in;

   logic                 seg_we;
   logic [SEG_AW-1:0]    seg_waddr, seg_raddr;
   seg_entry_type        seg_wdata, seg_rdata;

   logic [ADDR_BITS-1:0] ho_mem [MAX_HANDLES];
   logic                 ho_we;
   logic [HND_W-1:0]     ho_waddr, ho_raddr;
   logic [ADDR_BITS-1:0] ho_wdata, ho_rdata;

   logic [HND_W-1:0]     stk_mem [MAX_HANDLES];
   logic                 stk_we;
   logic [HND_W-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   logic [SIZE_W-1:0]    cfg_sat;
   logic                 split;
   logic                 rfree, lfree;
   logic [SIZE_W-1:0]    msum;
   logic [1:0]           rcnt;
   logic [SEG_CW:0]      jr;
   logic [SIZE_W-1:0]    eoff;

   ffha_seg_table #(
      .DEPTH (MAX_SEGMENTS),
      .AW    (SEG_AW)
   ) u_seg (
      .clock (clock),
      .we    (seg_we),
      .waddr (seg_waddr),
      .wdata (seg_wdata),
      .raddr (seg_raddr),
      .rdata (seg_rdata)
   );

   always_ff @(posedge clock) begin
      if (ho_we) begin
         ho_mem[ho_waddr] <= ho_wdata;
      end
      ho_rdata <= ho_mem[ho_raddr];
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata <= stk_mem[stk_raddr];
   end

   assign busy      = state_ff != S_IDLE;
   assign csr_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign cfg_sat = (csr_data == '0) ? SIZE_W'(1) :
                    (csr_data > POOL_MAX) ? POOL_MAX : csr_data;
   assign split   = cur_ff.size != req_ff.alloc_size;
   assign eoff    = {1'b0, seg_rdata.off};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pool_ff      <= POOL_MAX;
         cnt_ff       <= SEG_CW'(1);
         top_ff       <= '0;
         iss_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         stop_ff      <= 1'b0;
         nmov_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         iss_ff       <= iss_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         stop_ff      <= stop_in;
         nmov_ff      <= nmov_in;
      end
      idx_ff  <= idx_in;
      jdx_ff  <= jdx_in;
      req_ff  <= req_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      dst_ff  <= dst_in;
      pend_ff <= pend_in;
      hnd_ff  <= hnd_in;
      rm2_ff  <= rm2_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      pool_in      = pool_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      top_in       = top_ff;
      iss_in       = iss_ff;
      valid_in     = valid_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      dst_in       = dst_ff;
      nmov_in      = nmov_ff;
      pend_in      = pend_ff;
      hnd_in       = hnd_ff;
      rm2_in       = rm2_ff;
      stop_in      = stop_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      seg_we       = 1'b0;
      seg_waddr    = jdx_ff[SEG_AW-1:0];
      seg_wdata    = seg_rdata;
      seg_raddr    = idx_ff[SEG_AW-1:0];
      ho_we        = 1'b0;
      ho_waddr     = hnd_ff;
      ho_wdata     = cur_ff.off;
      ho_raddr     = req_item.handle;
      stk_we       = 1'b0;
      stk_waddr    = top_ff[HND_W-1:0];
      stk_wdata    = req_item.handle;
      stk_raddr    = top_ff[HND_W-1:0];
      rfree        = (({1'b0, idx_ff} + (SEG_CW + 1)'(1)) < {1'b0, cnt_ff}) &&
                     seg_rdata.free;
      lfree        = (idx_ff != '0) && prev_ff.free;
      msum         = cur_ff.size + (rfree ? seg_rdata.size : '0) +
                     (lfree ? prev_ff.size : '0);
      rcnt         = {1'b0, rfree} + {1'b0, lfree};
      jr           = {1'b0, jdx_ff} + (rm2_ff ? (SEG_CW + 1)'(2) : (SEG_CW + 1)'(1));

      case (state_ff)
         S_INIT: begin
            seg_we    = 1'b1;
            seg_waddr = '0;
            seg_wdata = '{off: '0, size: pool_ff, free: 1'b1, owner: '0};
            cnt_in    = SEG_CW'(1);
            top_in    = '0;
            iss_in    = '0;
            valid_in  = '0;
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            if (csr_valid) begin
               pool_in   = cfg_sat;
               seg_we    = 1'b1;
               seg_waddr = '0;
               seg_wdata = '{off: '0, size: cfg_sat, free: 1'b1, owner: '0};
               cnt_in    = SEG_CW'(1);
               top_in    = '0;
               iss_in    = '0;
               valid_in  = '0;
            end
            if (start) begin
               req_in  = req_item;
               idx_in  = '0;
               jdx_in  = '0;
               dst_in  = '0;
               nmov_in = '0;
               stop_in = 1'b0;
               case (req_item.req_type)
                  OP_ALLOC: begin
                     if (req_item.alloc_size == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = rsp_of(ST_NO_SPACE, '0, '0);
                     end else begin
                        state_in = S_A_RD;
                     end
                  end
                  OP_FREE, OP_DEREF: begin
                     if ({1'b0, req_item.handle} >= iss_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = rsp_of(ST_BAD_HANDLE, '0, '0);
                     end else if (!valid_ff[req_item.handle]) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = rsp_of(ST_FREED, '0, '0);
                     end else if (req_item.req_type == OP_DEREF) begin
                        state_in = S_D_OUT;
                     end else begin
                        valid_in[req_item.handle] = 1'b0;
                        if (top_ff < (HND_W + 1)'(MAX_HANDLES)) begin
                           stk_we = 1'b1;
                           top_in = top_ff + 1'b1;
                        end
                        state_in = S_F_RD;
                     end
                  end
                  default: begin
                     state_in = S_G_RD;
                  end
               endcase
            end
         end
         S_D_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_in       = rsp_of(ST_OK, '0, ho_rdata);
            state_in     = S_IDLE;
         end

         // alloc: first fit scan, handle pick, shift up, carve
         S_A_RD: begin
            if (idx_ff == cnt_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = rsp_of(ST_NO_SPACE, '0, '0);
               state_in     = S_IDLE;
            end else begin
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            if (seg_rdata.free && seg_rdata.size >= req_ff.alloc_size) begin
               cur_in = seg_rdata;
               jdx_in = cnt_ff;
               if ((top_ff == '0 && iss_ff >= (HND_W + 1)'(MAX_HANDLES)) ||
                   (seg_rdata.size != req_ff.alloc_size &&
                    {1'b0, cnt_ff} >= SEG_LIM)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = rsp_of(ST_FULL, '0, '0);
                  state_in     = S_IDLE;
               end else if (top_ff != '0) begin
                  top_in    = top_ff - 1'b1;
                  stk_raddr = HND_W'(top_ff - 1'b1);
                  state_in  = S_A_HND;
               end else begin
                  hnd_in   = iss_ff[HND_W-1:0];
                  iss_in   = iss_ff + 1'b1;
                  state_in = S_A_SH;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_A_RD;
            end
         end
         S_A_HND: begin
            hnd_in   = stk_rdata;
            state_in = S_A_SH;
         end
         S_A_SH: begin
            if (!split) begin
               state_in = S_A_WR0;
            end else if ({1'b0, jdx_ff} > ({1'b0, idx_ff} + (SEG_CW + 1)'(1))) begin
               seg_raddr = SEG_AW'(jdx_ff - 1'b1);
               state_in  = S_A_SHW;
            end else begin
               state_in = S_A_WR1;
            end
         end
         S_A_SHW: begin
            seg_we    = 1'b1;
            seg_waddr = jdx_ff[SEG_AW-1:0];
            jdx_in    = jdx_ff - 1'b1;
            state_in  = S_A_SH;
         end
         S_A_WR1: begin
            seg_we    = 1'b1;
            seg_waddr = SEG_AW'(idx_ff + 1'b1);
            seg_wdata = '{off:   ADDR_BITS'({1'b0, cur_ff.off} + req_ff.alloc_size),
                          size:  cur_ff.size - req_ff.alloc_size,
                          free:  1'b1,
                          owner: '0};
            cnt_in    = cnt_ff + 1'b1;
            state_in  = S_A_WR0;
         end
         S_A_WR0: begin
            seg_we           = 1'b1;
            seg_waddr        = idx_ff[SEG_AW-1:0];
            seg_wdata        = '{off: cur_ff.off, size: req_ff.alloc_size,
                                 free: 1'b0, owner: hnd_ff};
            valid_in[hnd_ff] = 1'b1;
            ho_we            = 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_in           = rsp_of(ST_OK, hnd_ff, cur_ff.off);
            state_in         = S_IDLE;
         end

         // free: find owner, merge both sides, shift down
         S_F_RD: begin
            if (idx_ff == cnt_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = rsp_of(ST_OK, '0, '0);
               state_in     = S_IDLE;
            end else begin
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            if (!seg_rdata.free && seg_rdata.owner == req_ff.handle) begin
               cur_in    = seg_rdata;
               seg_raddr = SEG_AW'(idx_ff + 1'b1);
               state_in  = S_F_MRG;
            end else begin
               prev_in  = seg_rdata;
               idx_in   = idx_ff + 1'b1;
               state_in = S_F_RD;
            end
         end
         S_F_MRG: begin
            seg_we = 1'b1;
            if (lfree) begin
               seg_waddr = SEG_AW'(idx_ff - 1'b1);
               seg_wdata = '{off: prev_ff.off, size: msum, free: 1'b1, owner: '0};
               jdx_in    = idx_ff;
            end else begin
               seg_waddr = idx_ff[SEG_AW-1:0];
               seg_wdata = '{off: cur_ff.off, size: msum, free: 1'b1, owner: '0};
               jdx_in    = idx_ff + 1'b1;
            end
            rm2_in = rcnt == 2'd2;
            if (rcnt == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = rsp_of(ST_OK, '0, '0);
               state_in     = S_IDLE;
            end else begin
               state_in = S_RM_RD;
            end
         end
         S_RM_RD: begin
            if (jr < {1'b0, cnt_ff}) begin
               seg_raddr = jr[SEG_AW-1:0];
               state_in  = S_RM_WR;
            end else begin
               cnt_in       = cnt_ff - (rm2_ff ? SEG_CW'(2) : SEG_CW'(1));
               rsp_valid_in = 1'b1;
               rsp_in       = rsp_of(ST_OK, '0, '0);
               state_in     = S_IDLE;
            end
         end
         S_RM_WR: begin
            seg_we    = 1'b1;
            seg_waddr = jdx_ff[SEG_AW-1:0];
            jdx_in    = jdx_ff + 1'b1;
            state_in  = S_RM_RD;
         end

         // defragment: compact in place, one move held back for last
         S_G_RD: begin
            state_in = (idx_ff == cnt_ff) ? S_G_END : S_G_CHK;
         end
         S_G_CHK: begin
            if (seg_rdata.free) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_G_RD;
            end else if (eoff != dst_ff && nmov_ff == (HND_W + 1)'(RESULT_CAP)) begin
               seg_we    = 1'b1;
               seg_wdata = '{off: dst_ff[ADDR_BITS-1:0], size: eoff - dst_ff,
                             free: 1'b1, owner: '0};
               jdx_in    = jdx_ff + 1'b1;
               stop_in   = 1'b1;
               state_in  = S_G_CPRD;
            end else begin
               if (eoff != dst_ff) begin
                  if (nmov_ff != '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_in          = '0;
                  pend_in.status   = ST_OK;
                  pend_in.move_src = seg_rdata.off;
                  pend_in.move_dst = dst_ff[ADDR_BITS-1:0];
                  pend_in.move_len = seg_rdata.size;
                  nmov_in          = nmov_ff + 1'b1;
                  ho_we            = 1'b1;
                  ho_waddr         = seg_rdata.owner;
                  ho_wdata         = dst_ff[ADDR_BITS-1:0];
               end
               seg_we    = 1'b1;
               seg_wdata = '{off: dst_ff[ADDR_BITS-1:0], size: seg_rdata.size,
                             free: 1'b0, owner: seg_rdata.owner};
               jdx_in    = jdx_ff + 1'b1;
               dst_in    = dst_ff + seg_rdata.size;
               idx_in    = idx_ff + 1'b1;
               state_in  = S_G_RD;
            end
         end
         S_G_CPRD: begin
            state_in = (idx_ff == cnt_ff) ? S_G_END : S_G_CPWR;
         end
         S_G_CPWR: begin
            seg_we   = 1'b1;
            jdx_in   = jdx_ff + 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = S_G_CPRD;
         end
         S_G_END: begin
            cnt_in = jdx_ff;
            if (!stop_ff && pool_ff > dst_ff && {1'b0, jdx_ff} < SEG_LIM) begin
               seg_we    = 1'b1;
               seg_wdata = '{off: dst_ff[ADDR_BITS-1:0], size: pool_ff - dst_ff,
                             free: 1'b1, owner: '0};
               cnt_in    = jdx_ff + 1'b1;
            end
            rsp_valid_in = 1'b1;
            if (nmov_ff == '0) begin
               rsp_in = rsp_of(ST_OK, '0, '0);
            end else begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_INIT |-> (cnt_ff != '0 && {1'b0, cnt_ff} <= SEG_LIM))
      else $error("segment count out of range");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= iss_ff)
      else $error("free stack deeper than handles issued");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("request accepted without progress");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=> busy)
      else $error("request ended without a last result");
`endif

endmodule

FILE: test/ffha_checker.sv
`timescale 1ns / 1ps

module ffha_checker
   import ffha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  ffha_req_type req_item,
   input  logic         rsp_valid,
   input  ffha_rsp_type rsp_item,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [16:0]  csr_data,
   output int           fail_count,
   output int           pending
);

   localparam int NSEG = 64;

   logic [15:0] seg_off [NSEG];
   logic [16:0] seg_len [NSEG];
   logic        seg_idle [NSEG];
   logic [5:0]  seg_hnd [NSEG];
   int          n_seg;
   logic        hnd_live [MAX_HANDLES];
   logic [15:0] hnd_off [MAX_HANDLES];
   logic [5:0]  hnd_stack [MAX_HANDLES];
   int          stack_depth;
   int          n_issued;
   logic [16:0] pool_bytes;

   ffha_rsp_type expected_rsps [$];
   int           mismatches;

   assign fail_count = mismatches;
   assign pending    = expected_rsps.size();

   function automatic ffha_rsp_type plain_rsp(status_type st);
      ffha_rsp_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

   task automatic add_expected(ffha_rsp_type r);
      expected_rsps = {expected_rsps, r};
   endtask

   task automatic clear_table();
      for (int k = 0; k < NSEG; k++) begin
         seg_idle[k] = 1'b0;
         seg_hnd[k]  = '0;
      end
      for (int k = 0; k < MAX_HANDLES; k++) hnd_live[k] = 1'b0;
      seg_off[0]  = '0;
      seg_len[0]  = pool_bytes;
      seg_idle[0] = 1'b1;
      n_seg       = 1;
      stack_depth = 0;
      n_issued    = 0;
   endtask

   task automatic drop_seg(int i);
      for (int k = i; k + 1 < n_seg; k++) begin
         seg_off[k]  = seg_off[k+1];
         seg_len[k]  = seg_len[k+1];
         seg_idle[k] = seg_idle[k+1];
         seg_hnd[k]  = seg_hnd[k+1];
      end
      n_seg--;
   endtask

   function automatic status_type handle_state(int h);
      if (h >= n_issued) return ST_BAD_HANDLE;
      if (!hnd_live[h]) return ST_FREED;
      return ST_OK;
   endfunction

   task automatic predict_alloc(int sz);
      int i, h;
      logic split;
      logic [15:0] off;
      ffha_rsp_type r;
      if (sz == 0) begin
         add_expected(plain_rsp(ST_NO_SPACE));
         return;
      end
      for (i = 0; i < n_seg; i++)
         if (seg_idle[i] && int'(seg_len[i]) >= sz) break;
      if (i == n_seg) begin
         add_expected(plain_rsp(ST_NO_SPACE));
         return;
      end
      split = int'(seg_len[i]) != sz;
      if ((stack_depth == 0 && n_issued >= MAX_HANDLES) || (split && n_seg >= NSEG)) begin
         add_expected(plain_rsp(ST_FULL));
         return;
      end
      if (stack_depth > 0) begin
         stack_depth--;
         h = int'(hnd_stack[stack_depth]);
      end else begin
         h = n_issued;
         n_issued++;
      end
      off = seg_off[i];
      if (split) begin
         for (int k = n_seg; k > i + 1; k--) begin
            seg_off[k]  = seg_off[k-1];
            seg_len[k]  = seg_len[k-1];
            seg_idle[k] = seg_idle[k-1];
            seg_hnd[k]  = seg_hnd[k-1];
         end
         n_seg++;
         seg_off[i+1]  = 16'(int'(off) + sz);
         seg_len[i+1]  = 17'(int'(seg_len[i]) - sz);
         seg_idle[i+1] = 1'b1;
         seg_hnd[i+1]  = '0;
         seg_len[i]    = 17'(sz);
      end
      seg_idle[i]  = 1'b0;
      seg_hnd[i]   = 6'(h);
      hnd_live[h]  = 1'b1;
      hnd_off[h]   = off;
      r            = plain_rsp(ST_OK);
      r.handle_out = 6'(h);
      r.offset     = off;
      add_expected(r);
   endtask

   task automatic predict_free(int h);
      status_type st;
      int i;
      st = handle_state(h);
      if (st != ST_OK) begin
         add_expected(plain_rsp(st));
         return;
      end
      for (i = 0; i < n_seg; i++)
         if (!seg_idle[i] && int'(seg_hnd[i]) == h) break;
      hnd_live[h] = 1'b0;
      if (stack_depth < MAX_HANDLES) begin
         hnd_stack[stack_depth] = 6'(h);
         stack_depth++;
      end
      if (i < n_seg) begin
         seg_idle[i] = 1'b1;
         seg_hnd[i]  = '0;
         if (i + 1 < n_seg && seg_idle[i+1]) begin
            seg_len[i] += seg_len[i+1];
            drop_seg(i + 1);
         end
         if (i > 0 && seg_idle[i-1]) begin
            seg_len[i-1] += seg_len[i];
            drop_seg(i);
         end
      end
      add_expected(plain_rsp(ST_OK));
   endtask

   task automatic predict_defrag();
      logic [15:0] n_off [NSEG];
      logic [16:0] n_len [NSEG];
      logic        n_idle [NSEG];
      logic [5:0]  n_hnd [NSEG];
      int i, j, dst, moves;
      logic stopped;
      ffha_rsp_type r;
      j = 0; dst = 0; moves = 0; stopped = 1'b0;
      for (int k = 0; k < NSEG; k++) begin
         n_off[k] = seg_off[k]; n_len[k] = seg_len[k];
         n_idle[k] = seg_idle[k]; n_hnd[k] = seg_hnd[k];
      end
      for (i = 0; i < n_seg; i++) begin
         if (seg_idle[i]) continue;
         if (int'(seg_off[i]) != dst) begin
            if (moves == RESULT_CAP) begin
               n_off[j] = 16'(dst); n_len[j] = 17'(int'(seg_off[i]) - dst);
               n_idle[j] = 1'b1; n_hnd[j] = '0;
               j++;
               for (; i < n_seg && j < NSEG; i++, j++) begin
                  n_off[j] = seg_off[i]; n_len[j] = seg_len[i];
                  n_idle[j] = seg_idle[i]; n_hnd[j] = seg_hnd[i];
               end
               stopped = 1'b1;
               break;
            end
            r          = '0;
            r.move_src = seg_off[i];
            r.move_dst = 16'(dst);
            r.move_len = seg_len[i];
            add_expected(r);
            moves++;
            hnd_off[seg_hnd[i]] = 16'(dst);
         end
         n_off[j] = 16'(dst); n_len[j] = seg_len[i]; n_idle[j] = 1'b0; n_hnd[j] = seg_hnd[i];
         j++;
         dst += int'(seg_len[i]);
      end
      if (!stopped && int'(pool_bytes) > dst && j < NSEG) begin
         n_off[j] = 16'(dst); n_len[j] = 17'(int'(pool_bytes) - dst);
         n_idle[j] = 1'b1; n_hnd[j] = '0;
         j++;
      end
      for (int k = 0; k < NSEG; k++) begin
         seg_off[k] = n_off[k]; seg_len[k] = n_len[k];
         seg_idle[k] = n_idle[k]; seg_hnd[k] = n_hnd[k];
      end
      n_seg = j;
      if (moves == 0) add_expected(plain_rsp(ST_OK));
      else expected_rsps[$].last = 1'b1;
   endtask

   task automatic predict_request(ffha_req_type q);
      status_type st;
      ffha_rsp_type r;
      case (q.req_type)
         OP_ALLOC: predict_alloc(int'(q.alloc_size));
         OP_FREE:  predict_free(int'(q.handle));
         OP_DEREF: begin
            st = handle_state(int'(q.handle));
            r  = plain_rsp(st);
            if (st == ST_OK) r.offset = hnd_off[q.handle];
            add_expected(r);
         end
         default:  predict_defrag();
      endcase
   endtask

   task automatic compare_rsp(ffha_rsp_type got);
      ffha_rsp_type want;
      if (expected_rsps.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %p", got);
         return;
      end
      want = expected_rsps.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("response mismatch: expected %p got %p", want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pool_bytes = POOL_MAX;
         clear_table();
         expected_rsps.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid) compare_rsp(rsp_item);
         if (csr_valid && csr_ready) begin
            pool_bytes = (csr_data == 0) ? 17'd1 : (csr_data > POOL_MAX ? POOL_MAX : csr_data);
            clear_table();
         end
         if (start && !busy) predict_request(req_item);
      end
   end

endmodule

FILE: test/tb_first_fit_handle_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_handle_allocator;
   import ffha_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   ffha_req_type req_item = '0;
   logic         rsp_valid;
   ffha_rsp_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [16:0]  csr_data = '0;
   int           fail_count;
   int           pending;
   int           live_hint;

   always #6 clock = ~clock;

   first_fit_handle_allocator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   ffha_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   task automatic send_request(req_op_type op, int sz, int h, logic may_idle);
      if (may_idle)
         while ($urandom_range(99) < 19) @(negedge clock);
      req_item.req_type   = op;
      req_item.alloc_size = SIZE_W'(sz);
      req_item.handle     = HND_W'(h);
      start               = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start    = 1'b0;
      req_item = '0;
   endtask

   task automatic drain_and_write(logic [16:0] val);
      int guard;
      guard = 0;
      while ((pending != 0 || busy) && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (300) @(negedge clock);
      csr_data  = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_phase(int n, int max_sz, logic may_idle);
      int pick;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 45)
            send_request(OP_ALLOC, $urandom_range(max_sz, 1), 0, may_idle);
         else if (pick < 75)
            send_request(OP_FREE, 0, $urandom_range(live_hint + 2), may_idle);
         else if (pick < 92)
            send_request(OP_DEREF, 0, $urandom_range(63), may_idle);
         else
            send_request(OP_DEFRAG, 0, 0, may_idle);
         if (live_hint < 63) live_hint++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      live_hint = 4;
      // directed
      send_request(OP_ALLOC, 0, 0, 1'b0);
      send_request(OP_DEREF, 0, 63, 1'b0);
      send_request(OP_DEFRAG, 0, 0, 1'b0);
      send_request(OP_ALLOC, 65536, 0, 1'b0);
      send_request(OP_ALLOC, 1, 0, 1'b0);
      send_request(OP_FREE, 0, 0, 1'b0);
      send_request(OP_FREE, 0, 0, 1'b0);
      send_request(OP_DEREF, 0, 0, 1'b0);
      send_request(OP_ALLOC, 1000, 0, 1'b0);
      send_request(OP_ALLOC, 2000, 0, 1'b0);
      send_request(OP_ALLOC, 3000, 0, 1'b0);
      send_request(OP_ALLOC, 131071, 0, 1'b0);
      send_request(OP_FREE, 0, 1, 1'b0);
      send_request(OP_FREE, 0, 0, 1'b0);
      send_request(OP_DEREF, 0, 2, 1'b0);
      send_request(OP_DEFRAG, 0, 0, 1'b0);
      send_request(OP_DEREF, 0, 2, 1'b0);
      send_request(OP_ALLOC, 64536, 0, 1'b0);
      send_request(OP_ALLOC, 1, 0, 1'b0);
      // tiny pool, table and handle exhaustion
      drain_and_write(17'd0);
      send_request(OP_ALLOC, 1, 0, 1'b0);
      send_request(OP_ALLOC, 1, 0, 1'b0);
      drain_and_write(17'd100);
      for (int k = 0; k < 66; k++) send_request(OP_ALLOC, 1, 0, 1'b0);
      for (int k = 0; k < 64; k += 2) send_request(OP_FREE, 0, k, 1'b0);
      send_request(OP_DEFRAG, 0, 0, 1'b0);
      send_request(OP_DEREF, 0, 63, 1'b0);
      // random phases
      drain_and_write(17'd131071);
      live_hint = 4;
      random_phase(35, 4000, 1'b1);
      drain_and_write(17'd65536);
      live_hint = 4;
      random_phase(25, 3000, 1'b0);
      drain_and_write(17'd300);
      live_hint = 4;
      random_phase(40, 40, 1'b1);
      drain_and_write(17'd1);
      send_request(OP_ALLOC, 1, 0, 1'b1);
      send_request(OP_DEFRAG, 0, 0, 1'b1);
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0) $display("[first_fit_handle_allocator] OK");
      else $display("[first_fit_handle_allocator] ERROR");
      $finish;
   end

   initial begin
      #80ms;
      $display("[first_fit_handle_allocator] ERROR");
      $finish;
   end

endmodule
